[design/nrr_pkg.sv]
package nrr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int EARLY_DEPTH = 16;
  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EARLY_W = (EARLY_DEPTH > 1) ? $clog2(EARLY_DEPTH) : 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int US_PER_MS = 1000;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_EARLY  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_RTT    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_MULT  = 3'd0,
    CFG_RESEND_MULT = 3'd1,
    CFG_MAX_RETRIES = 3'd2,
    CFG_TIMEOUT_MS  = 3'd3,
    CFG_MIN_FIRST   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SCAN_FIND = 2'd0,
    SCAN_MIN  = 2'd1,
    SCAN_NEXT = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DIV, ST_WALK, ST_EVICT_SCAN, ST_EVICT_DRAIN,
    ST_EVICT_WRITE, ST_FIND_SCAN, ST_FIND_DRAIN, ST_PRUNE, ST_TICK_SETUP,
    ST_NEXT_SCAN, ST_NEXT_DRAIN, ST_FETCH, ST_EVAL
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [47:0] created;
    logic [47:0] sent;
    logic [7:0]  retries;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       capture;
    logic       first_pkt;
    logic       set_highest;
    logic       pkt_setup;
    logic       div_step;
    logic       walk_advance;
    logic       walk_insert_free;
    logic       walk_insert_best;
    logic       scan_start;
    scan_mode_t scan_mode;
    logic       scan_step;
    logic       prune;
    logic       early_add;
    logic       rtt_set;
    logic       tick_init;
    logic       tick_calc2;
    logic       eval;
    logic       flush;
  } nrr_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  started;
    logic  gap;
    logic  equal;
    logic  k_nz;
    logic  div_last;
    logic  walk_done;
    logic  walk_skip;
    logic  table_full;
    logic  idx_last;
    logic  found;
  } nrr_stat_t;

endpackage

[design/nrr_ram.sv]
module nrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nrr_ctrl.sv]
module nrr_ctrl import nrr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  nrr_stat_t stat,
  output nrr_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd = '0;
    cmd.scan_mode = SCAN_FIND;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.kind)
          KIND_PACKET: begin
            priority if (!stat.started) begin
              cmd.first_pkt = 1'b1;
              state_next = ST_IDLE;
            end else if (stat.gap) begin
              cmd.pkt_setup = 1'b1;
              state_next = stat.k_nz ? ST_DIV : ST_WALK;
            end else if (stat.equal) begin
              cmd.set_highest = 1'b1;
              state_next = ST_PRUNE;
            end else begin
              cmd.scan_start = 1'b1;
              cmd.scan_mode = SCAN_FIND;
              state_next = ST_FIND_SCAN;
            end
          end
          KIND_EARLY: begin
            cmd.early_add = 1'b1;
            state_next = ST_IDLE;
          end
          KIND_TICK: begin
            cmd.tick_init = 1'b1;
            state_next = ST_TICK_SETUP;
          end
          KIND_RTT: begin
            cmd.rtt_set = 1'b1;
            state_next = ST_IDLE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_WALK;
      end
      ST_WALK: begin
        priority if (stat.walk_done) begin
          cmd.set_highest = 1'b1;
          state_next = ST_PRUNE;
        end else if (stat.walk_skip) begin
          cmd.walk_advance = 1'b1;
        end else if (!stat.table_full) begin
          cmd.walk_insert_free = 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_mode = SCAN_MIN;
          state_next = ST_EVICT_SCAN;
        end
      end
      ST_EVICT_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) state_next = ST_EVICT_DRAIN;
      end
      ST_EVICT_DRAIN: state_next = ST_EVICT_WRITE;
      ST_EVICT_WRITE: begin
        cmd.walk_insert_best = 1'b1;
        state_next = ST_WALK;
      end
      ST_FIND_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.idx_last) state_next = ST_FIND_DRAIN;
      end
      ST_FIND_DRAIN: state_next = ST_PRUNE;
      ST_PRUNE: begin
        cmd.prune = 1'b1;
        state_next = ST_IDLE;
      end
      ST_TICK_SETUP: begin
        cmd.tick_calc2 = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode = SCAN_NEXT;
        state_next = ST_NEXT_SCAN;
      end
      ST_NEXT_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_mode = SCAN_NEXT;
        if (stat.idx_last) state_next = ST_NEXT_DRAIN;
      end
      ST_NEXT_DRAIN: state_next = ST_FETCH;
      ST_FETCH: begin
        if (stat.found) begin
          state_next = ST_EVAL;
        end else begin
          cmd.flush = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        cmd.scan_start = 1'b1;
        cmd.scan_mode = SCAN_NEXT;
        state_next = ST_NEXT_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[design/nrr_datapath.sv]
module nrr_datapath import nrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            kind,
  input  logic [31:0]           seq,
  input  logic [31:0]           group_seq,
  input  logic [7:0]            fec_data_count,
  input  logic [7:0]            fec_repair_count,
  input  logic [47:0]           now_us,
  input  logic [15:0]           rtt_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  nrr_cmd_t              cmd,
  output nrr_stat_t             stat,
  output logic                  nack_valid,
  output logic [31:0]           nack_seq,
  output logic                  last
);

  // configuration
  logic [4:0]  first_mult, resend_mult;
  logic [7:0]  max_retries, min_first_ms;
  logic [15:0] timeout_ms;

  // block state
  logic                   started;
  logic [31:0]            highest_seq, highest_gseq;
  logic [15:0]            current_rtt;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [EARLY_DEPTH-1:0] early_valid;
  logic [31:0]            early_seq [EARLY_DEPTH];

  // captured item
  kind_t       item_kind;
  logic [31:0] item_seq, item_gseq;
  logic [7:0]  item_k, item_r;
  logic [47:0] item_now;
  logic [15:0] item_rtt;

  // scan unit
  logic [ADDR_W-1:0] idx, idx_d, best_idx;
  logic              cmp_en, found;
  scan_mode_t        mode;
  logic [31:0]       best_seq;

  // gap walk and FEC remainder
  logic [31:0] walk_i, walk_j, div_dividend;
  logic [8:0]  fec_rem;
  logic [4:0]  div_cnt;

  // tick
  logic [31:0] prev_seq, pend_seq;
  logic        have_prev, pend_valid;
  logic [20:0] first_ms, resend_ms;
  logic [30:0] first_us, resend_us;
  logic [25:0] timeout_us;

  // memory
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;

  // combinational helpers
  logic [32:0]       next_seq, gap_len;
  logic [31:0]       walk_start, j_start;
  logic [8:0]        fec_mod;
  logic [9:0]        rem_sh;
  logic [8:0]        rem_inc;
  logic              walk_early_hit, item_early_hit, early_has_free;
  logic [EARLY_W-1:0] early_free;
  logic              has_free;
  logic [ADDR_W-1:0] free_idx;
  logic              due, retire;
  logic [7:0]        new_ret;
  logic [48:0]       first_due, resend_due, timeout_at;

  assign next_seq = {1'b0, highest_seq} + 33'd1;
  assign gap_len  = {1'b0, item_seq} - next_seq;
  assign walk_start = (gap_len > 33'(TABLE_DEPTH)) ? item_seq - 32'(TABLE_DEPTH)
                                                   : next_seq[31:0];
  assign j_start = highest_gseq + 32'd1 + (walk_start - next_seq[31:0]);
  assign fec_mod = {1'b0, item_k} + {1'b0, item_r};
  assign rem_sh  = {fec_rem, div_dividend[31]};
  assign rem_inc = fec_rem + 9'd1;

  always_comb begin
    walk_early_hit = 1'b0;
    item_early_hit = 1'b0;
    early_has_free = 1'b0;
    early_free = '0;
    for (int e = EARLY_DEPTH - 1; e >= 0; e--) begin
      if (early_valid[e] && early_seq[e] == walk_i) walk_early_hit = 1'b1;
      if (early_valid[e] && early_seq[e] == item_seq) item_early_hit = 1'b1;
      if (!early_valid[e]) begin
        early_has_free = 1'b1;
        early_free = EARLY_W'(e);
      end
    end
  end

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int e = TABLE_DEPTH - 1; e >= 0; e--) begin
      if (!entry_valid[e]) begin
        has_free = 1'b1;
        free_idx = ADDR_W'(e);
      end
    end
  end

  // due and retirement test on the fetched entry
  assign first_due  = {1'b0, rd.created} + 49'(first_us);
  assign resend_due = {1'b0, rd.sent} + 49'(resend_us);
  assign timeout_at = {1'b0, rd.created} + 49'(timeout_us);
  assign due = (rd.retries == 8'd0) ? ({1'b0, item_now} > first_due)
                                    : ({1'b0, item_now} > resend_due);
  assign new_ret = (rd.retries != 8'hFF) ? rd.retries + 8'd1 : rd.retries;
  assign retire = (rd.retries != 8'd0) &&
                  ((new_ret >= max_retries) || ({1'b0, item_now} >= timeout_at));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = '{seq: walk_i, created: item_now, sent: 48'd0, retries: 8'd0};
    if (cmd.walk_insert_free) begin
      ram_we = 1'b1;
    end else if (cmd.walk_insert_best) begin
      ram_we = 1'b1;
      ram_waddr = best_idx;
    end else if (cmd.eval && due) begin
      ram_we = 1'b1;
      ram_waddr = best_idx;
      ram_wdata = '{seq: rd.seq, created: rd.created, sent: item_now, retries: new_ret};
    end
  end

  assign ram_raddr = cmd.scan_step ? idx : best_idx;

  nrr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_comb begin
    stat.kind       = item_kind;
    stat.started    = started;
    stat.gap        = {1'b0, item_seq} > next_seq;
    stat.equal      = {1'b0, item_seq} == next_seq;
    stat.k_nz       = item_k != 8'd0;
    stat.div_last   = div_cnt == 5'd31;
    stat.walk_done  = walk_i == item_seq;
    stat.walk_skip  = ((item_k != 8'd0) && (fec_rem >= {1'b0, item_k})) || walk_early_hit;
    stat.table_full = !has_free;
    stat.idx_last   = idx == ADDR_W'(TABLE_DEPTH - 1);
    stat.found      = found;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_mult   <= 5'd2;
      resend_mult  <= 5'd2;
      max_retries  <= 8'd10;
      timeout_ms   <= 16'd1000;
      min_first_ms <= 8'd20;
      started      <= 1'b0;
      highest_seq  <= '0;
      highest_gseq <= '0;
      current_rtt  <= '0;
      entry_valid  <= '0;
      early_valid  <= '0;
      cmp_en       <= 1'b0;
      found        <= 1'b0;
      have_prev    <= 1'b0;
      pend_valid   <= 1'b0;
      nack_valid   <= 1'b0;
    end else begin
      nack_valid <= 1'b0;
      cmp_en <= cmd.scan_step;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIRST_MULT:  first_mult   <= cfg_data[4:0];
          CFG_RESEND_MULT: resend_mult  <= cfg_data[4:0];
          CFG_MAX_RETRIES: max_retries  <= cfg_data[7:0];
          CFG_TIMEOUT_MS:  timeout_ms   <= cfg_data;
          CFG_MIN_FIRST:   min_first_ms <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.first_pkt) started <= 1'b1;
      if (cmd.first_pkt || cmd.set_highest) begin
        highest_seq  <= item_seq;
        highest_gseq <= item_gseq;
      end
      if (cmd.rtt_set) current_rtt <= item_rtt;
      if (cmd.early_add && !item_early_hit && early_has_free) begin
        early_valid[early_free] <= 1'b1;
      end
      if (cmd.prune) begin
        for (int e = 0; e < EARLY_DEPTH; e++) begin
          if (early_seq[e] <= highest_seq) early_valid[e] <= 1'b0;
        end
      end
      if (cmd.walk_insert_free) entry_valid[free_idx] <= 1'b1;
      if (cmd.scan_start) found <= 1'b0;
      if (cmp_en) begin
        unique case (mode)
          SCAN_FIND: begin
            if (entry_valid[idx_d] && rd.seq == item_seq) entry_valid[idx_d] <= 1'b0;
          end
          SCAN_MIN: begin
            if (!found || rd.seq < best_seq) found <= 1'b1;
          end
          SCAN_NEXT: begin
            if (entry_valid[idx_d] && (!have_prev || rd.seq > prev_seq) &&
                (!found || rd.seq < best_seq)) found <= 1'b1;
          end
          default: ;
        endcase
      end
      if (cmd.tick_init) begin
        have_prev  <= 1'b0;
        pend_valid <= 1'b0;
      end
      if (cmd.eval) begin
        have_prev <= 1'b1;
        if (due) begin
          if (retire) entry_valid[best_idx] <= 1'b0;
          pend_valid <= 1'b1;
          if (pend_valid) nack_valid <= 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
        if (pend_valid) nack_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_kind <= kind_t'(kind);
      item_seq  <= seq;
      item_gseq <= group_seq;
      item_k    <= fec_data_count;
      item_r    <= fec_repair_count;
      item_now  <= now_us;
      item_rtt  <= rtt_ms;
    end
    if (cmd.early_add && !item_early_hit && early_has_free) begin
      early_seq[early_free] <= item_seq;
    end
    if (cmd.pkt_setup) begin
      walk_i       <= walk_start;
      walk_j       <= j_start;
      div_dividend <= j_start;
      fec_rem      <= '0;
      div_cnt      <= '0;
    end
    if (cmd.div_step) begin
      fec_rem      <= (rem_sh >= {1'b0, fec_mod}) ? 9'(rem_sh - {1'b0, fec_mod})
                                                  : rem_sh[8:0];
      div_dividend <= {div_dividend[30:0], 1'b0};
      div_cnt      <= div_cnt + 5'd1;
    end
    if (cmd.walk_advance || cmd.walk_insert_free || cmd.walk_insert_best) begin
      walk_i  <= walk_i + 32'd1;
      walk_j  <= walk_j + 32'd1;
      fec_rem <= ((&walk_j) || rem_inc == fec_mod) ? 9'd0 : rem_inc;
    end
    if (cmd.scan_start) begin
      idx  <= '0;
      mode <= cmd.scan_mode;
    end
    if (cmd.scan_step) begin
      idx   <= idx + ADDR_W'(1);
      idx_d <= idx;
    end
    if (cmp_en) begin
      unique case (mode)
        SCAN_FIND: ;
        SCAN_MIN: begin
          if (!found || rd.seq < best_seq) begin
            best_seq <= rd.seq;
            best_idx <= idx_d;
          end
        end
        SCAN_NEXT: begin
          if (entry_valid[idx_d] && (!have_prev || rd.seq > prev_seq) &&
              (!found || rd.seq < best_seq)) begin
            best_seq <= rd.seq;
            best_idx <= idx_d;
          end
        end
        default: ;
      endcase
    end
    if (cmd.tick_init) begin
      first_ms  <= (current_rtt < {8'd0, min_first_ms}) ? {13'd0, min_first_ms}
                                                      : first_mult * current_rtt;
      resend_ms <= resend_mult * current_rtt;
    end
    if (cmd.tick_calc2) begin
      first_us   <= 31'(first_ms) * 31'(US_PER_MS);
      resend_us  <= 31'(resend_ms) * 31'(US_PER_MS);
      timeout_us <= 26'(timeout_ms) * 26'(US_PER_MS);
    end
    if (cmd.eval) begin
      prev_seq <= rd.seq;
      if (due) begin
        pend_seq <= rd.seq;
        nack_seq <= pend_seq;
        last     <= 1'b0;
      end
    end
    if (cmd.flush) begin
      nack_seq <= pend_seq;
      last     <= 1'b1;
    end
  end

endmodule

[design/nack_retransmit_requester_top.sv]
// NACK retransmit requester. Drive start with one item (packet, early notice,
// timer tick or RTT update); it is taken when start is high and busy is low.
// Requests come out on nack_valid/nack_seq one cycle each with no back
// pressure: the receiver must take every transfer, and last marks the final
// one of a tick. Item work is set by the 64-entry table, one RAM read per
// cycle while it is scanned: RTT and notice items and an in-order packet need
// no scan, a late packet one table scan, a gap up to 64 inserts plus a serial
// remainder division when FEC is on, and each insert into a full table costs
// a scan for the smallest sequence instead of a direct write. A tick scans the
// table once per entry visited plus a final scan. Config writes are always
// ready and must only be issued while busy is low and no request is pending.
module nack_retransmit_requester_top import nrr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic [31:0]           seq,
  input  logic [31:0]           group_seq,
  input  logic [7:0]            fec_data_count,
  input  logic [7:0]            fec_repair_count,
  input  logic                  is_retransmit,
  input  logic [47:0]           now_us,
  input  logic [15:0]           rtt_ms,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  nack_valid,
  output logic [31:0]           nack_seq,
  output logic                  last
);

  nrr_cmd_t  cmd;
  nrr_stat_t stat;
  logic      retx_unused;

  // the retransmit flag does not change behavior: late packets clear alike
  assign retx_unused = is_retransmit;
  assign cfg_ready = 1'b1;

  nrr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  nrr_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .kind             (kind),
    .seq              (seq),
    .group_seq        (group_seq),
    .fec_data_count   (fec_data_count),
    .fec_repair_count (fec_repair_count),
    .now_us           (now_us),
    .rtt_ms           (rtt_ms),
    .cfg_we           (cfg_valid & cfg_ready & ~retx_unused | cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .nack_valid       (nack_valid),
    .nack_seq         (nack_seq),
    .last             (last)
  );

endmodule
